@@ sv/dfi_pkg.sv @@
// Shared types, register map and coefficient helpers for the direct form I IIR filter.
// Depends on nothing; every other file of the block imports it.
package dfi_pkg;

  localparam int DFI_MAX_TAPS    = 8;
  localparam int DFI_SAMPLE_BITS = 16;
  localparam int COEF_W          = 16;
  localparam int PORT_W          = 16;
  localparam int CFG_DATA_W      = 64;
  localparam int CFG_ADDR_W      = 6;
  localparam int ORDER_W         = 3;
  localparam int REG_IDX_W       = 3;

  // register indexes, byte address = 8 * index
  localparam logic [REG_IDX_W-1:0] REG_ORDER  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_NUM_LO = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_NUM_HI = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_DEN_LO = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_DEN_HI = 3'd4;

  localparam logic [ORDER_W-1:0]    RST_ORDER  = '0;
  localparam logic [CFG_DATA_W-1:0] RST_NUM_LO = 64'd4096;
  localparam logic [CFG_DATA_W-1:0] RST_NUM_HI = 64'd0;
  localparam logic [CFG_DATA_W-1:0] RST_DEN_LO = 64'd4096;
  localparam logic [CFG_DATA_W-1:0] RST_DEN_HI = 64'd0;

  typedef enum logic [1:0] {
    CMD_FILTER = 2'd0,
    CMD_OFFSET = 2'd1,
    CMD_PRESET = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_FLUSH,
    S_DIVST,
    S_DIV,
    S_DONE
  } state_t;

  typedef struct packed {
    cmd_t                     command;
    logic signed [PORT_W-1:0] sample_value;
  } in_item_t;

  typedef struct packed {
    logic signed [PORT_W-1:0] filtered_value;
    logic                     saturated;
    logic                     divide_error;
  } out_item_t;

  typedef struct packed {
    logic issue;
    logic clear;
    logic sub;
  } mac_ctrl_t;

  // pick one Q4.12 coefficient out of a low/high register pair
  function automatic logic signed [COEF_W-1:0] coef_sel(
    input logic [CFG_DATA_W-1:0] lo,
    input logic [CFG_DATA_W-1:0] hi,
    input logic [2:0]            idx
  );
    logic [CFG_DATA_W-1:0] word;
    word = idx[2] ? hi : lo;
    return $signed(word[COEF_W*idx[1:0] +: COEF_W]);
  endfunction

endpackage

@@ sv/direct_form_iir_filter.sv @@
// Top level of the direct form I IIR filter: register port, histories and sequencer.
// Depends on dfi_pkg, dfi_mac and dfi_div.
//
// Direct form I IIR filter of order N (0..7) with N+1 taps, capped at MAX_TAPS. Coefficients
// are signed Q4.12, four to a 64-bit register, written over the APB port at byte address
// 8*index; the user must write them only while the block is idle, which the block does not
// enforce. A filter item shifts its sample into the input history and computes
// (sum B_i*x_i - sum A_i*y_i) / A0, truncated toward zero and clamped to the sample range;
// the result enters the output history. A0 equal to zero yields 0 with divide_error. An
// offset item adds its value to every history entry with clamping; a preset item loads every
// entry with the clamped value; the unused command only reports the latest output. Every
// item returns one result carrying output_history[0]. A filter item passes its 2*T-1
// products, T being the tap count, one per cycle through the single multiplier, and the
// divider then retires one quotient bit per cycle over ACC_W bits, the accumulator width
// ACC_W being SAMPLE_BITS + 16 + clog2(2*MAX_TAPS). With A0 equal to zero the divider is
// skipped. All other commands go from accept straight to the result. The histories are
// cleared by reset directly, with no clearing pass. The input side stalls while an item is
// in work; a finished result sits in the output register, so the next item may be taken
// while that result waits.
module direct_form_iir_filter import dfi_pkg::*; #(
  parameter int MAX_TAPS    = DFI_MAX_TAPS,
  parameter int SAMPLE_BITS = DFI_SAMPLE_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input items
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  // result items
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  // register port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int GROW   = $clog2(2 * MAX_TAPS);
  localparam int ACC_W  = SAMPLE_BITS + COEF_W + GROW;
  localparam int QW     = ACC_W + 1;
  localparam int CNT_W  = $clog2(2 * MAX_TAPS) > 0 ? $clog2(2 * MAX_TAPS) : 1;
  localparam int IDX_W  = MAX_TAPS > 1 ? $clog2(MAX_TAPS) : 1;
  localparam logic signed [QW-1:0] SMAX = {{(QW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [QW-1:0] SMIN = ~SMAX;

  // clamp to the sample range; top bit flags a clip
  function automatic logic [SAMPLE_BITS:0] clamp_fn(input logic signed [QW-1:0] x);
    logic                clip;
    logic signed [QW-1:0] y;
    clip = 1'b0;
    y    = x;
    if (x > SMAX) begin
      y    = SMAX;
      clip = 1'b1;
    end else if (x < SMIN) begin
      y    = SMIN;
      clip = 1'b1;
    end
    return {clip, y[SAMPLE_BITS-1:0]};
  endfunction

  // ---------------------------------------------------------------- register port
  logic [ORDER_W-1:0]    order_r;
  logic [CFG_DATA_W-1:0] num_lo_r;
  logic [CFG_DATA_W-1:0] num_hi_r;
  logic [CFG_DATA_W-1:0] den_lo_r;
  logic [CFG_DATA_W-1:0] den_hi_r;
  logic [REG_IDX_W-1:0]  reg_idx;
  logic                  cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_ADDR_W-1:CFG_ADDR_W-REG_IDX_W];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r  <= RST_ORDER;
      num_lo_r <= RST_NUM_LO;
      num_hi_r <= RST_NUM_HI;
      den_lo_r <= RST_DEN_LO;
      den_hi_r <= RST_DEN_HI;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_ORDER:  order_r  <= pwdata[ORDER_W-1:0];
        REG_NUM_LO: num_lo_r <= pwdata;
        REG_NUM_HI: num_hi_r <= pwdata;
        REG_DEN_LO: den_lo_r <= pwdata;
        REG_DEN_HI: den_hi_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ORDER:  prdata = CFG_DATA_W'(order_r);
      REG_NUM_LO: prdata = num_lo_r;
      REG_NUM_HI: prdata = num_hi_r;
      REG_DEN_LO: prdata = den_lo_r;
      REG_DEN_HI: prdata = den_hi_r;
      default:    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- state
  state_t                        state_r, state_nxt;
  logic [CNT_W-1:0]              k_r, k_nxt;
  logic [CNT_W-1:0]              taps_r, taps_nxt;
  logic [CNT_W-1:0]              last_r, last_nxt;
  logic                          sat_r, sat_nxt;
  logic                          err_r, err_nxt;
  logic signed [SAMPLE_BITS-1:0] xh_r [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] yh_r [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] xh_nxt [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] yh_nxt [MAX_TAPS];
  logic                          out_valid_r, out_valid_nxt;
  out_item_t                     out_data_r, out_data_nxt;

  // ---------------------------------------------------------------- datapath helpers
  logic signed [QW-1:0]          v_ext;
  logic                          v_clip;
  logic signed [SAMPLE_BITS-1:0] v_sat;
  logic                          off_clip;
  logic signed [SAMPLE_BITS-1:0] xo [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] yo [MAX_TAPS];
  logic [3:0]                    ord_p1;
  logic [3:0]                    taps4;
  logic [4:0]                    last5;
  logic                          is_num;
  logic [CNT_W-1:0]              den_k;
  logic [2:0]                    coef_idx;
  logic signed [COEF_W-1:0]      mac_coef;
  logic signed [SAMPLE_BITS-1:0] mac_smp;
  logic signed [COEF_W-1:0]      a0;
  logic                          a0_zero;
  mac_ctrl_t                     mac_ctrl;
  logic signed [ACC_W-1:0]       mac_acc;
  logic                          div_start;
  logic                          div_done;
  logic signed [QW-1:0]          div_q;
  logic                          q_clip;
  logic signed [SAMPLE_BITS-1:0] q_sat;
  logic signed [QW-1:0]          y0_ext;

  always_comb begin
    v_ext            = QW'($signed(in_data.sample_value));
    {v_clip, v_sat}  = clamp_fn(v_ext);
    off_clip         = 1'b0;
    for (int i = 0; i < MAX_TAPS; i++) begin
      logic c0;
      logic c1;
      {c0, xo[i]} = clamp_fn(QW'(xh_r[i]) + v_ext);
      {c1, yo[i]} = clamp_fn(QW'(yh_r[i]) + v_ext);
      off_clip    = off_clip | c0 | c1;
    end
    {q_clip, q_sat} = clamp_fn(div_q);
    y0_ext          = QW'(yh_r[0]);
  end

  // tap count, capped at the history depth
  always_comb begin
    ord_p1 = {1'b0, order_r} + 4'd1;
    taps4  = (ord_p1 > 4'(MAX_TAPS)) ? 4'(MAX_TAPS) : ord_p1;
    last5  = {taps4, 1'b0} - 5'd2;
  end

  // term k: numerator B_k*x_k while k < taps, then denominator A_j*y_j, j = k - taps + 1
  always_comb begin
    is_num   = k_r < taps_r;
    den_k    = k_r - taps_r + 1'b1;
    coef_idx = is_num ? 3'(k_r) : 3'(den_k);
    mac_coef = is_num ? coef_sel(num_lo_r, num_hi_r, coef_idx)
                      : coef_sel(den_lo_r, den_hi_r, coef_idx);
    mac_smp  = is_num ? xh_r[IDX_W'(k_r)] : yh_r[IDX_W'(den_k)];
    a0       = coef_sel(den_lo_r, den_hi_r, 3'd0);
    a0_zero  = a0 == '0;
    mac_ctrl.issue = state_r == S_MAC;
    mac_ctrl.clear = k_r == '0;
    mac_ctrl.sub   = !is_num;
  end

  dfi_mac #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .ACC_W       (ACC_W)
  ) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (mac_ctrl),
    .coef  (mac_coef),
    .smp   (mac_smp),
    .acc   (mac_acc)
  );

  dfi_div #(
    .DVD_W (ACC_W),
    .DVS_W (COEF_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mac_acc),
    .divisor  (a0),
    .done     (div_done),
    .quotient (div_q)
  );

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    taps_nxt      = taps_r;
    last_nxt      = last_r;
    sat_nxt       = sat_r;
    err_nxt       = err_r;
    xh_nxt        = xh_r;
    yh_nxt        = yh_r;
    div_start     = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          err_nxt   = 1'b0;
          state_nxt = S_DONE;
          case (in_data.command)
            CMD_FILTER: begin
              // advance both histories, newest at index 0
              for (int i = MAX_TAPS - 1; i > 0; i--) begin
                xh_nxt[i] = xh_r[i-1];
                yh_nxt[i] = yh_r[i-1];
              end
              xh_nxt[0] = v_sat;
              yh_nxt[0] = '0;
              sat_nxt   = v_clip;
              k_nxt     = '0;
              taps_nxt  = CNT_W'(taps4);
              last_nxt  = CNT_W'(last5);
              state_nxt = S_MAC;
            end
            CMD_OFFSET: begin
              xh_nxt  = xo;
              yh_nxt  = yo;
              sat_nxt = off_clip;
            end
            CMD_PRESET: begin
              for (int i = 0; i < MAX_TAPS; i++) begin
                xh_nxt[i] = v_sat;
                yh_nxt[i] = v_sat;
              end
              sat_nxt = v_clip;
            end
            default: begin
              sat_nxt = 1'b0;
            end
          endcase
        end
      end
      S_MAC: begin
        if (k_r == last_r) begin
          state_nxt = S_FLUSH;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_FLUSH: begin
        // last product lands in the accumulator
        state_nxt = S_DIVST;
      end
      S_DIVST: begin
        if (a0_zero) begin
          err_nxt   = 1'b1;
          yh_nxt[0] = '0;
          state_nxt = S_DONE;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          yh_nxt[0] = q_sat;
          sat_nxt   = sat_r | q_clip;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!(out_valid_r && out_stall)) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.filtered_value = y0_ext[PORT_W-1:0];
          out_data_nxt.saturated      = sat_r;
          out_data_nxt.divide_error   = err_r;
          state_nxt                   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= '0;
      taps_r      <= '0;
      last_r      <= '0;
      sat_r       <= 1'b0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_TAPS; i++) begin
        xh_r[i] <= '0;
        yh_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      taps_r      <= taps_nxt;
      last_r      <= last_nxt;
      sat_r       <= sat_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
      xh_r        <= xh_nxt;
      yh_r        <= yh_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------- assertions
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after an item was taken");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished outside the divide state");

  a_term_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MAC) |-> (k_r <= last_r && taps_r != '0))
    else $error("term counter beyond the last tap");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !(out_valid_r && out_stall)) |=> (out_valid && state_r == S_IDLE))
    else $error("finished item not moved to the output register");

  a_zero_a0: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIVST && a0_zero) |=> (err_r && yh_r[0] == '0 && state_r == S_DONE))
    else $error("zero A0 not reported");

endmodule

@@ sv/dfi_mac.sv @@
// Shared multiply-accumulate unit of the IIR filter: registered product, then accumulate.
// Depends on dfi_pkg.
module dfi_mac import dfi_pkg::*; #(
  parameter int SAMPLE_BITS = DFI_SAMPLE_BITS,
  parameter int ACC_W       = DFI_SAMPLE_BITS + COEF_W + 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mac_ctrl_t                     ctrl,
  input  logic signed [COEF_W-1:0]      coef,
  input  logic signed [SAMPLE_BITS-1:0] smp,
  output logic signed [ACC_W-1:0]       acc
);

  localparam int PROD_W = COEF_W + SAMPLE_BITS;

  logic                     prod_vld_r;
  logic                     clr_r;
  logic                     sub_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  term;
  logic signed [ACC_W-1:0]  acc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= ctrl.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.issue) begin
      prod_r <= coef * smp;
      clr_r  <= ctrl.clear;
      sub_r  <= ctrl.sub;
    end
    if (prod_vld_r) begin
      acc_r <= acc_nxt;
    end
  end

  always_comb begin
    term    = ACC_W'(prod_r);
    acc_nxt = (clr_r ? '0 : acc_r) + (sub_r ? -term : term);
  end

  assign acc = acc_r;

endmodule

@@ sv/dfi_div.sv @@
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on dfi_pkg.
module dfi_div import dfi_pkg::*; #(
  parameter int DVD_W = DFI_SAMPLE_BITS + COEF_W + 4,
  parameter int DVS_W = COEF_W
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [DVD_W-1:0] dividend,
  input  logic signed [DVS_W-1:0] divisor,
  output logic                    done,
  output logic signed [DVD_W:0]   quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0] q_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] d_r;
  logic             neg_r;

  logic [DVD_W-1:0] dvd_mag;
  logic [DVS_W-1:0] dvs_mag;
  logic [DVS_W:0]   rem_sh;
  logic             ge;
  logic [DVS_W-1:0] rem_nxt;
  logic [DVD_W:0]   q_ext;

  always_comb begin
    dvd_mag = dividend[DVD_W-1] ? (~dividend + 1'b1) : dividend;
    dvs_mag = divisor[DVS_W-1] ? (~divisor + 1'b1) : divisor;
    rem_sh  = {rem_r, q_r[DVD_W-1]};
    ge      = rem_sh >= {1'b0, d_r};
    rem_nxt = ge ? DVS_W'(rem_sh - {1'b0, d_r}) : rem_sh[DVS_W-1:0];
    q_ext   = {1'b0, q_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dvd_mag;
      rem_r <= '0;
      d_r   <= dvs_mag;
      neg_r <= dividend[DVD_W-1] ^ divisor[DVS_W-1];
    end else if (busy_r) begin
      q_r   <= {q_r[DVD_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? $signed(~q_ext + 1'b1) : $signed(q_ext);

endmodule
